// ===== sv/assert_macros.svh =====
// Assertion helpers used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fosjq_pkg.sv =====
package fosjq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_W          = 64;
  localparam int LEN_W         = 64;
  localparam int OCC_W         = 5;
  localparam int LIMIT_W       = 5;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_LIMIT = 8'd1;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_SJN  = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // latch request, pos <= tail, moved <= 0
    logic rd_head;    // read address is head, else slot before pos
    logic shift;      // slot[pos] <= slot before pos, step pos back
    logic place;      // write new job at pos, advance tail
    logic deq_take;   // pop head into result
    logic res_reject;
    logic res_empty;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic sjn;
    logic greater;    // slot before pos is longer than the new job
    logic more;       // another queued job lies before pos
  } sts_t;

endpackage

// ===== sv/fosjq_ram.sv =====
module fosjq_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fosjq_ctrl.sv =====
module fosjq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fosjq_pkg::sts_t sts,
  output fosjq_pkg::cmd_t cmd
);

  import fosjq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_PLACE    = 7'b0001000,
    S_DEQ_RD   = 7'b0010000,
    S_DEQ_TAKE = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          if (sts.is_deq) begin
            if (sts.empty) begin
              cmd.res_empty = 1'b1;
              state_next    = S_FINISH;
            end else begin
              state_next = S_DEQ_RD;
            end
          end else if (sts.full) begin
            cmd.res_reject = 1'b1;
            state_next     = S_FINISH;
          end else if (sts.sjn && !sts.empty) begin
            state_next = S_SCAN_RD;
          end else begin
            state_next = S_PLACE;
          end
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.greater) begin
          cmd.shift  = 1'b1;
          state_next = sts.more ? S_SCAN_RD : S_PLACE;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FINISH;
      end
      S_DEQ_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_DEQ_TAKE;
      end
      S_DEQ_TAKE: begin
        cmd.deq_take = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/fosjq_datapath.sv =====
`include "assert_macros.svh"

module fosjq_datapath #(
  parameter int DEPTH = fosjq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fosjq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fosjq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                kind,
  input  logic [fosjq_pkg::ID_W-1:0]          job_id,
  input  logic [fosjq_pkg::LEN_W-1:0]         job_length,
  output logic [1:0]                          status,
  output logic [fosjq_pkg::ID_W-1:0]          head_id,
  output logic [fosjq_pkg::LEN_W-1:0]         head_length,
  output logic [fosjq_pkg::OCC_W-1:0]         occupancy,
  input  fosjq_pkg::cmd_t                     cmd,
  output fosjq_pkg::sts_t                     sts
);

  import fosjq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int EW = $bits(entry_t);

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic                 policy_mode;
  logic [LIMIT_W-1:0]   queue_limit;
  logic [AW-1:0]        head_pos;
  logic [AW-1:0]        tail_pos;
  logic [CW-1:0]        fill;
  logic [AW-1:0]        pos;
  logic [CW-1:0]        moved;
  logic [ID_W-1:0]      req_id;
  logic [LEN_W-1:0]     req_len;
  status_t              res_status;
  logic [ID_W-1:0]      res_id;
  logic [LEN_W-1:0]     res_len;

  logic [LW-1:0]        limit_ext;
  logic [LW-1:0]        limit_eff;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  entry_t               rd_entry;
  entry_t               new_entry;

  assign cfg_ready = 1'b1;

  // effective limit saturates at the ring depth
  assign limit_ext = LW'(queue_limit);
  assign limit_eff = (limit_ext > LW'(DEPTH)) ? LW'(DEPTH) : limit_ext;

  assign rd_entry       = entry_t'(ram_rdata);
  assign new_entry.id   = req_id;
  assign new_entry.len  = req_len;

  assign sts.is_deq  = (kind == KIND_DEQ);
  assign sts.full    = (LW'(fill) >= limit_eff);
  assign sts.empty   = (fill == '0);
  assign sts.sjn     = (policy_mode == POLICY_SJN);
  assign sts.greater = (rd_entry.len > req_len);
  assign sts.more    = (CW'(moved + 1'b1) < fill);

  assign ram_raddr = cmd.rd_head ? head_pos : ring_prev(pos);
  assign ram_we    = cmd.shift | cmd.place;
  assign ram_waddr = pos;
  assign ram_wdata = cmd.shift ? ram_rdata : EW'(new_entry);

  fosjq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= POLICY_FIFO;
      queue_limit <= LIMIT_RESET;
      head_pos    <= '0;
      tail_pos    <= '0;
      fill        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_POLICY_MODE: policy_mode <= cfg_data[0];
          REG_QUEUE_LIMIT: queue_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.place) begin
        tail_pos <= ring_next(tail_pos);
        fill     <= fill + 1'b1;
      end
      if (cmd.deq_take) begin
        head_pos <= ring_next(head_pos);
        fill     <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_id  <= job_id;
      req_len <= job_length;
      pos     <= tail_pos;
      moved   <= '0;
    end
    if (cmd.shift) begin
      pos   <= ring_prev(pos);
      moved <= moved + 1'b1;
    end
    if (cmd.res_reject) begin
      res_status <= ST_FULL;
      res_id     <= '0;
      res_len    <= '0;
    end
    if (cmd.res_empty) begin
      res_status <= ST_EMPTY;
      res_id     <= '0;
      res_len    <= '0;
    end
    if (cmd.place) begin
      res_status <= ST_ACCEPTED;
      res_id     <= '0;
      res_len    <= '0;
    end
    if (cmd.deq_take) begin
      res_status <= ST_DEQUEUED;
      res_id     <= rd_entry.id;
      res_len    <= rd_entry.len;
    end
    if (cmd.load_out) begin
      status      <= res_status;
      head_id     <= res_id;
      head_length <= res_len;
      occupancy   <= OCC_W'(fill);
    end
  end

  `ASSERT_IMP(a_fill_bound, 1'b1, fill <= CW'(DEPTH), "fill count above depth")
  `ASSERT_IMP(a_shift_ok, cmd.shift, sts.greater && (moved < fill), "shift past queued jobs")
  `ASSERT_NXT(a_place_count, cmd.place, fill == $past(fill) + 1'b1, "place did not count up")

endmodule

// ===== sv/fifo_or_shortest_job_queue.sv =====
// Bounded job queue of DEPTH entries in FIFO or shortest-job-next order. One request is
// taken at a time; the next one is accepted as soon as the previous result sits in the
// output register. A rejected enqueue or an empty dequeue goes straight to its result, a
// dequeue reads the head slot and then pops it, a FIFO enqueue (or any enqueue into an
// empty queue) writes the job at the tail, and a shortest-job-next enqueue first moves
// jobs back one slot from the tail while they are longer. Each move costs a read and a
// write of the single slot memory, whose read port is registered. Configuration writes
// are taken at any time and must only be issued while no request is in flight.
module fifo_or_shortest_job_queue #(
  parameter int DEPTH = fosjq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fosjq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fosjq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [fosjq_pkg::ID_W-1:0]        job_id,
  input  logic [fosjq_pkg::LEN_W-1:0]       job_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [fosjq_pkg::ID_W-1:0]        head_id,
  output logic [fosjq_pkg::LEN_W-1:0]       head_length,
  output logic [fosjq_pkg::OCC_W-1:0]       occupancy
);

  import fosjq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fosjq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fosjq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .job_id      (job_id),
    .job_length  (job_length),
    .status      (status),
    .head_id     (head_id),
    .head_length (head_length),
    .occupancy   (occupancy),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
